/* src/ljp_pkg.sv */
// shared types, field widths, codes and helpers for the lennard-jones pair energy block
package ljp_pkg;

   // field widths
   localparam int DIST_W       = 22;
   localparam int RAD_W        = 19;
   localparam int DEPTH_W      = 17;
   localparam int CLASS_W      = 2;
   localparam int SCALE_W      = 17;
   localparam int PE_W         = 32;
   localparam int TOT_W        = 48;
   localparam int RADIUS_SUM_W = RAD_W + 1;
   localparam int DEPTH_PROD_W = 2 * DEPTH_W;
   localparam int EPS_W        = DEPTH_W;
   localparam int POW_CAP_BITS = 32;
   localparam int SCALE_BITS   = 16;
   localparam int MAG_W        = 64;

   // pair classes
   localparam logic [CLASS_W-1:0] CLASS_NORMAL   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_EXCLUDED = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_ONE_FOUR = 2'd2;

   // multiply operations, issued in this order
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_Q2    = 3'd0;
   localparam logic [OP_W-1:0] OP_Q4    = 3'd1;
   localparam logic [OP_W-1:0] OP_Q6    = 3'd2;
   localparam logic [OP_W-1:0] OP_Q12   = 3'd3;
   localparam logic [OP_W-1:0] OP_EPS   = 3'd4;
   localparam logic [OP_W-1:0] OP_SCALE = 3'd5;

   localparam logic [PE_W-1:0]    E_MAX       = 32'h7fff_ffff;
   localparam logic [PE_W-1:0]    E_MIN       = 32'h8000_0000;
   localparam logic [TOT_W-1:0]   TOTAL_MAX   = 48'h7fff_ffff_ffff;
   localparam logic [TOT_W-1:0]   TOTAL_MIN   = 48'h8000_0000_0000;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd32768;

   // controller to datapath
   typedef struct packed {
      logic            load;
      logic            iter;
      logic            mul_start;
      logic            take;
      logic            finish;
      logic [OP_W-1:0] op;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;
      logic stop;
      logic scale_needed;
      logic mul_done;
      logic out_busy;
   } status_type;

   // sign and magnitude to saturated 32-bit energy, sat flag on top
   function automatic logic [PE_W:0] clamp_energy(input logic neg, input logic [MAG_W-1:0] mag);
      logic [PE_W:0] res;
      if (neg) begin
         if (mag > MAG_W'(E_MIN)) res = {1'b1, E_MIN};
         else res = {1'b0, ~mag[PE_W-1:0] + PE_W'(1)};
      end else begin
         if (mag > MAG_W'(E_MAX)) res = {1'b1, E_MAX};
         else res = {1'b0, mag[PE_W-1:0]};
      end
      return res;
   endfunction

endpackage

/* src/ljp_mul.sv */
// shared multiplier: four half-width partial products accumulated over cycles
module ljp_mul import ljp_pkg::*; #(
   parameter int OPW = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [OPW-1:0]   a,
   input  logic [OPW-1:0]   b,
   output logic             done,
   output logic [2*OPW-1:0] prod
);

   localparam int HW = (OPW + 1) / 2;

   logic [2*HW-1:0] a_ff, b_ff;
   logic [2:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [2*HW-1:0] pp_ff, pp_in;
   logic [1:0]      psel_ff, psel_in;
   logic [4*HW-1:0] acc_ff, acc_in;
   logic [HW-1:0]   xa, xb;
   logic [4*HW-1:0] pp_aligned;

   // operand halves picked by the step count
   assign xa = cnt_ff[1] ? a_ff[2*HW-1:HW] : a_ff[HW-1:0];
   assign xb = cnt_ff[0] ? b_ff[2*HW-1:HW] : b_ff[HW-1:0];

   // align the registered partial product
   always_comb begin
      unique case (psel_ff)
         2'd0:    pp_aligned = (4*HW)'(pp_ff);
         2'd1,
         2'd2:    pp_aligned = (4*HW)'(pp_ff) << HW;
         default: pp_aligned = (4*HW)'(pp_ff) << (2 * HW);
      endcase
   end

   // step control
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      pp_in   = pp_ff;
      psel_in = psel_ff;
      acc_in  = acc_ff;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff != 3'd4) begin
            pp_in   = xa * xb;
            psel_in = cnt_ff[1:0];
         end
         if (cnt_ff != 3'd0) acc_in = acc_ff + pp_aligned;
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= (2*HW)'(a);
         b_ff <= (2*HW)'(b);
      end
      pp_ff   <= pp_in;
      psel_ff <= psel_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff[2*OPW-1:0];

endmodule

/* src/ljp_dp.sv */
// datapath: divider, square root, power chain, clamps, running total and result register
module ljp_dp import ljp_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic [DIST_W-1:0]         req_distance,
   input  logic [RAD_W-1:0]          req_radius_a,
   input  logic [RAD_W-1:0]          req_radius_b,
   input  logic [DEPTH_W-1:0]        req_depth_a,
   input  logic [DEPTH_W-1:0]        req_depth_b,
   input  logic [CLASS_W-1:0]        req_pair_class,
   input  logic                      req_last_pair,
   input  logic                      csr_valid,
   input  logic [SCALE_W-1:0]        csr_one_four_scale,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [PE_W-1:0]    rsp_pair_energy,
   output logic signed [TOT_W-1:0]   rsp_total_energy,
   output logic                      rsp_saturated,
   output logic                      rsp_sum_done
);

   localparam int NW  = RADIUS_SUM_W + FRAC_BITS;
   localparam int PW  = FRAC_BITS + POW_CAP_BITS;
   localparam int OPW = PW + 2;
   localparam int PRW = 2 * OPW;

   // divider
   logic [NW-1:0]     dq_ff;
   logic [DIST_W-1:0] rem_ff;
   logic [DIST_W-1:0] r_ff;
   logic [DIST_W:0]   rem_sh;
   logic              div_ge;
   // square root
   logic [DEPTH_PROD_W-1:0] sx_ff, sres_ff, trial;
   logic [DEPTH_PROD_W-2:0] sbit_ff;
   // powers and energy
   logic [PW-1:0]  p2_ff, p4_ff, p6_ff, p12_ff;
   logic           neg_ff;
   logic [PE_W-1:0] pe_ff, pe_abs;
   logic           sat_ff, excl_ff, zero_ff, ovf_ff, one4_ff, last_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [TOT_W-1:0]   total_ff;
   // multiplier hookup
   logic [OPW-1:0] mul_a, mul_b, two_q6, lj_mag;
   logic           mul_done;
   logic [PRW-1:0] prod, pow_sh, scale_sh;
   logic [PW-1:0]  pw_val;
   logic           pow_ovf;
   // running total
   logic [TOT_W:0]   sum_wide;
   logic [TOT_W-1:0] sum_clamped;
   logic             sum_over;
   // result register
   logic             rsp_valid_ff;
   logic [PE_W-1:0]  rsp_pe_ff;
   logic [TOT_W-1:0] rsp_total_ff;
   logic             rsp_sat_ff, rsp_done_ff;

   // divider step: one quotient bit a cycle
   assign rem_sh = {rem_ff, dq_ff[NW-1]};
   assign div_ge = rem_sh >= {1'b0, r_ff};

   // square root trial value
   assign trial = sres_ff + DEPTH_PROD_W'(sbit_ff);

   // multiplier operand select
   assign two_q6 = OPW'({p6_ff, 1'b0});
   assign lj_mag = neg_ff ? two_q6 - OPW'(p12_ff) : OPW'(p12_ff) - two_q6;
   assign pe_abs = pe_ff[PE_W-1] ? ~pe_ff + PE_W'(1) : pe_ff;

   always_comb begin
      unique case (cmd.op)
         OP_Q2: begin
            mul_a = OPW'(dq_ff);
            mul_b = OPW'(dq_ff);
         end
         OP_Q4: begin
            mul_a = OPW'(p2_ff);
            mul_b = OPW'(p2_ff);
         end
         OP_Q6: begin
            mul_a = OPW'(p4_ff);
            mul_b = OPW'(p2_ff);
         end
         OP_Q12: begin
            mul_a = OPW'(p6_ff);
            mul_b = OPW'(p6_ff);
         end
         OP_EPS: begin
            mul_a = lj_mag;
            mul_b = OPW'(sres_ff[EPS_W-1:0]);
         end
         OP_SCALE: begin
            mul_a = OPW'(pe_abs);
            mul_b = OPW'(scale_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   ljp_mul #(.OPW(OPW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   // product rescaling and power overflow check
   assign pow_sh   = prod >> FRAC_BITS;
   assign scale_sh = prod >> SCALE_BITS;
   assign pw_val   = pow_sh[PW-1:0];
   assign pow_ovf  = (pow_sh >> PW) != '0;

   // running total with 48-bit saturation
   assign sum_wide = {total_ff[TOT_W-1], total_ff} + (TOT_W+1)'($signed(pe_ff));
   assign sum_over = sum_wide[TOT_W] != sum_wide[TOT_W-1];
   assign sum_clamped = sum_over ? (sum_wide[TOT_W] ? TOTAL_MIN : TOTAL_MAX)
                                 : sum_wide[TOT_W-1:0];

   // item registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff    <= req_distance;
         dq_ff   <= {{1'b0, req_radius_a} + {1'b0, req_radius_b}, {FRAC_BITS{1'b0}}};
         rem_ff  <= '0;
         sx_ff   <= DEPTH_PROD_W'(req_depth_a) * DEPTH_PROD_W'(req_depth_b);
         sres_ff <= '0;
         sbit_ff <= (DEPTH_PROD_W-1)'(1) << (DEPTH_PROD_W - 2);
         excl_ff <= !(req_pair_class == CLASS_NORMAL || req_pair_class == CLASS_ONE_FOUR);
         zero_ff <= req_distance == '0;
         one4_ff <= req_pair_class == CLASS_ONE_FOUR;
         last_ff <= req_last_pair;
         ovf_ff  <= 1'b0;
         if (req_pair_class == CLASS_NORMAL || req_pair_class == CLASS_ONE_FOUR) begin
            pe_ff  <= E_MAX;
            sat_ff <= req_distance == '0;
         end else begin
            pe_ff  <= '0;
            sat_ff <= 1'b0;
         end
      end else if (cmd.iter) begin
         rem_ff <= div_ge ? DIST_W'(rem_sh - {1'b0, r_ff}) : rem_sh[DIST_W-1:0];
         dq_ff  <= {dq_ff[NW-2:0], div_ge};
         if (sbit_ff != '0) begin
            if (sx_ff >= trial) begin
               sx_ff   <= sx_ff - trial;
               sres_ff <= (sres_ff >> 1) + DEPTH_PROD_W'(sbit_ff);
            end else begin
               sres_ff <= sres_ff >> 1;
            end
            sbit_ff <= sbit_ff >> 2;
         end
      end else if (cmd.take) begin
         unique case (cmd.op)
            OP_Q2:    p2_ff <= pw_val;
            OP_Q4:    p4_ff <= pw_val;
            OP_Q6:    p6_ff <= pw_val;
            OP_Q12: begin
               p12_ff <= pw_val;
               neg_ff <= {1'b0, pw_val} < {p6_ff, 1'b0};
            end
            OP_EPS:   {sat_ff, pe_ff} <= clamp_energy(neg_ff, pow_sh[MAG_W-1:0]);
            OP_SCALE: {sat_ff, pe_ff} <= clamp_energy(pe_ff[PE_W-1], scale_sh[MAG_W-1:0]);
            default:  ;
         endcase
         // any power past the cap saturates like zero distance
         if ((cmd.op == OP_Q2 || cmd.op == OP_Q4 || cmd.op == OP_Q6 || cmd.op == OP_Q12)
             && pow_ovf) begin
            ovf_ff <= 1'b1;
            pe_ff  <= E_MAX;
            sat_ff <= 1'b1;
         end
      end
   end

   // control state: scale register, total, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_RESET;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) scale_ff <= csr_one_four_scale;
         if (cmd.finish) begin
            total_ff     <= last_ff ? '0 : sum_clamped;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_pe_ff    <= pe_ff;
         rsp_total_ff <= sum_clamped;
         rsp_sat_ff   <= sat_ff | sum_over;
         rsp_done_ff  <= last_ff;
      end
   end

   assign status.skip         = excl_ff | zero_ff;
   assign status.stop         = ovf_ff;
   assign status.scale_needed = one4_ff & ~sat_ff;
   assign status.mul_done     = mul_done;
   assign status.out_busy     = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pair_energy  = rsp_pe_ff;
   assign rsp_total_energy = rsp_total_ff;
   assign rsp_saturated    = rsp_sat_ff;
   assign rsp_sum_done     = rsp_done_ff;

endmodule

/* src/ljp_ctrl.sv */
// controller state machine sequencing divide, square root and the multiply chain
module ljp_ctrl import ljp_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output cmd_type    cmd,
   input  status_type status
);

   localparam int NW = RADIUS_SUM_W + FRAC_BITS;
   localparam int CW = $clog2(NW);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [OP_W-1:0] op_ff, op_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (status.skip) begin
               state_in = S_FIN;
            end else begin
               cmd.iter = 1'b1;
               cnt_in   = cnt_ff + CW'(1);
               if (cnt_ff == CW'(NW - 1)) begin
                  op_in    = OP_Q2;
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            if (status.stop || (op_ff == OP_SCALE && !status.scale_needed)) begin
               state_in = S_FIN;
            end else begin
               cmd.mul_start = 1'b1;
               state_in      = S_WAIT;
            end
         end
         S_WAIT: begin
            if (status.mul_done) begin
               cmd.take = 1'b1;
               if (op_ff == OP_SCALE) begin
                  state_in = S_FIN;
               end else begin
                  op_in    = op_ff + OP_W'(1);
                  state_in = S_START;
               end
            end
         end
         S_FIN: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         op_ff    <= OP_Q2;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         op_ff    <= op_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

endmodule

/* src/lennard_jones_pair_energy_sum.sv */
// Lennard-Jones 12-6 pair energy with a saturating running sum per molecule.
// One pair at a time: a restoring divider forms q = R/r at one bit a cycle
// (RADIUS_SUM_W + FRAC_BITS = 36 quotient bits at FRAC_BITS = 16) while the well depth
// square root runs alongside, then one shared multiplier built from four
// half-width partial products works through q^2, q^4, q^6, q^12, the well
// depth and the 1-4 scale; an excluded or zero-distance pair skips both the
// divider and the multiplies. A pair's result waits for the previous result to
// leave the output register. The result sits in an output register, so the next
// transaction is taken while it waits. Write one_four_scale only while idle.
module lennard_jones_pair_energy_sum import ljp_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [DIST_W-1:0]       req_distance,
   input  logic [RAD_W-1:0]        req_radius_a,
   input  logic [RAD_W-1:0]        req_radius_b,
   input  logic [DEPTH_W-1:0]      req_depth_a,
   input  logic [DEPTH_W-1:0]      req_depth_b,
   input  logic [CLASS_W-1:0]      req_pair_class,
   input  logic                    req_last_pair,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [PE_W-1:0]  rsp_pair_energy,
   output logic signed [TOT_W-1:0] rsp_total_energy,
   output logic                    rsp_saturated,
   output logic                    rsp_sum_done,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [SCALE_W-1:0]      csr_one_four_scale
);

   cmd_type    cmd;
   status_type status;

   // scale register is always writable
   assign csr_ready = 1'b1;

   ljp_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   ljp_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_distance       (req_distance),
      .req_radius_a       (req_radius_a),
      .req_radius_b       (req_radius_b),
      .req_depth_a        (req_depth_a),
      .req_depth_b        (req_depth_b),
      .req_pair_class     (req_pair_class),
      .req_last_pair      (req_last_pair),
      .csr_valid          (csr_valid),
      .csr_one_four_scale (csr_one_four_scale),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pair_energy    (rsp_pair_energy),
      .rsp_total_energy   (rsp_total_energy),
      .rsp_saturated      (rsp_saturated),
      .rsp_sum_done       (rsp_sum_done)
   );

`ifndef SYNTHESIS
   // busy after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready again right after accepting a transaction");

   // every multiplier result is consumed
   a_done_taken: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> cmd.take)
      else $error("multiplier result dropped");

   // finishing always presents a result
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished transaction not presented");
`endif

endmodule
